FILE: hdl/cbkm_pkg.sv
// Shared types, codes and bank-select helpers for the cartridge bank mapper.
package cbkm_pkg;

	// Item kinds carried on the slave-side tuser
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Register page that the D000-DFFF window maps to
	localparam logic [3:0] REG_PAGE = 4'hD;

	// Exact page addresses that update derived state or select a glyph read
	localparam logic [15:0] ADDR_WRAM0   = 16'hD000;
	localparam logic [15:0] ADDR_WRAM1   = 16'hD100;
	localparam logic [15:0] ADDR_PRG0    = 16'hD200;
	localparam logic [15:0] ADDR_PRG1    = 16'hD300;
	localparam logic [15:0] ADDR_PRG2    = 16'hD400;
	localparam logic [15:0] ADDR_CHR     = 16'hD500;
	localparam logic [15:0] ADDR_IRQ_LO  = 16'hD600;
	localparam logic [15:0] ADDR_IRQ_HI  = 16'hD700;
	localparam logic [15:0] ADDR_IRQ_ACK = 16'hD800;
	localparam logic [15:0] ADDR_IRQ_CTL = 16'hD900;
	localparam logic [15:0] ADDR_MIRROR  = 16'hDA00;
	localparam logic [15:0] ADDR_GLYPH_T = 16'hDC00;
	localparam logic [15:0] ADDR_GLYPH_B = 16'hDD00;

	// Register file slots read by fixed logic
	localparam int REG_MIRROR    = 10;
	localparam int REG_GLYPH_CFG = 11;
	localparam int REG_GLYPH_COL = 12;
	localparam int REG_GLYPH_ROW = 13;

	localparam logic [7:0] GLYPH_BASE  = 8'h20;
	localparam logic [7:0] GLYPH_SPAN  = 8'h60;
	localparam logic [5:0] GLYPH_PAGES = 6'h24;

	typedef logic [7:0] reg_byte_t;

	// Glyph lookup inputs
	typedef struct packed {
		logic [15:0] address;
		reg_byte_t   cfg;
		reg_byte_t   col;
		reg_byte_t   row;
	} glyph_req_t;

	// Input word: tuser = opcode, tdata = {cycle_count, write_data, address}
	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  cycle_count;
		logic [7:0]  write_data;
		logic [15:0] address;
	} in_item_t;

	// Result word, lowest field last
	typedef struct packed {
		logic [1:0] pad;
		logic       irq_line;
		logic [1:0] nametable_control;
		logic       mirroring;
		logic       chr_bank_low;
		logic [1:0] wram_bank_7000;
		logic [1:0] wram_bank_6000;
		logic [6:0] prg_bank_c000;
		logic [6:0] prg_bank_a000;
		logic [6:0] prg_bank_8000;
		logic [7:0] read_data;
	} out_item_t;

	function automatic logic [6:0] prg_select(input reg_byte_t r);
		if (r[6]) begin
			return 7'h10 + {1'b0, r[5:0]};
		end
		return {3'd0, r[3:0]};
	endfunction

	function automatic logic [1:0] wram_select(input reg_byte_t r);
		return {r[3], r[0]};
	endfunction

	// Page remap for the glyph tile index
	function automatic logic [3:0] glyph_page(input logic [5:0] p);
		case (p)
			6'd0, 6'd1:   return 4'h0;
			6'd2, 6'd3:   return 4'h2;
			6'd4, 6'd5:   return 4'h1;
			6'd6:         return 4'h4;
			6'd7:         return 4'h5;
			6'd8:         return 4'h6;
			6'd9:         return 4'h7;
			6'd10:        return 4'h8;
			6'd11:        return 4'h9;
			6'd12:        return 4'hA;
			6'd13:        return 4'hB;
			6'd14:        return 4'hC;
			6'd15:        return 4'hD;
			6'd16:        return 4'hE;
			6'd17:        return 4'hF;
			6'd34, 6'd35: return 4'hD;
			default: begin
				if (p >= 6'd18 && p <= 6'd33) begin
					return 4'(p - 6'd18);
				end
				return 4'h0;
			end
		endcase
	endfunction

endpackage

FILE: hdl/cartridge_bank_irq_kanji_mapper_core.sv
// Top level of the cartridge bank mapper: bus decode, bank state, cycle IRQ.
// Path: an accepted word is held in the input register, then written into the result
//   register, which drives m_tvalid.
// Throughput: one word per cycle; the input register drains into the result
//   register whenever that register is empty or being taken.
// Reset (arst_n low, asynchronous): registers and banks clear, mirroring
//   reads one, the IRQ is idle and both stages are empty.
module cartridge_bank_irq_kanji_mapper_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // address[15:0], write_data[23:16], cycle_count[31:24]
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // read_data[7:0], prg_bank_8000[14:8],
	                              // prg_bank_a000[21:15], prg_bank_c000[28:22],
	                              // wram_bank_6000[30:29], wram_bank_7000[32:31],
	                              // chr_bank_low[33], mirroring[34],
	                              // nametable_control[36:35], irq_line[37], zero[39:38]
);
	import cbkm_pkg::*;

	// Input stage
	in_item_t  item_s1;
	logic      valid_s1;
	logic      adv_s1;

	// Result stage
	out_item_t out_q;
	logic      out_valid_q;

	// Mapper state
	reg_byte_t   rf_q [16];
	logic [6:0]  prg_q [3];
	logic [1:0]  wram_q [2];
	logic        chr_q;
	logic        mirror_q;
	logic [1:0]  nt_q;
	logic [15:0] reload_q;
	logic [16:0] cnt_q;
	logic        irq_en_q;
	logic        irq_rep_q;
	logic        irq_pend_q;

	// Next state
	reg_byte_t   rf_d [16];
	logic [6:0]  prg_d [3];
	logic [1:0]  wram_d [2];
	logic        chr_d;
	logic        mirror_d;
	logic [1:0]  nt_d;
	logic [15:0] reload_d;
	logic [16:0] cnt_d;
	logic        irq_en_d;
	logic        irq_rep_d;
	logic        irq_pend_d;
	logic [16:0] cnt_sum;
	logic [7:0]  rd_d;

	glyph_req_t  glyph_req;
	logic [7:0]  glyph_data;

	// The input stage moves on whenever the result register can take a word
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= {s_tuser, s_tdata};
		end
	end

	// Glyph lookup sees the register file as it stands before this word
	assign glyph_req = '{
		address: item_s1.address,
		cfg:     rf_q[REG_GLYPH_CFG],
		col:     rf_q[REG_GLYPH_COL],
		row:     rf_q[REG_GLYPH_ROW]
	};

	cbkm_glyph u_glyph (
		.req  (glyph_req),
		.data (glyph_data)
	);

	assign cnt_sum = cnt_q + {9'd0, item_s1.cycle_count};

	always_comb begin
		rf_d       = rf_q;
		prg_d      = prg_q;
		wram_d     = wram_q;
		chr_d      = chr_q;
		mirror_d   = mirror_q;
		nt_d       = nt_q;
		reload_d   = reload_q;
		cnt_d      = cnt_q;
		irq_en_d   = irq_en_q;
		irq_rep_d  = irq_rep_q;
		irq_pend_d = irq_pend_q;
		rd_d       = '0;
		case (item_s1.opcode)
			OP_WRITE: begin
				if (item_s1.address[15:12] == REG_PAGE) begin
					rf_d[item_s1.address[11:8]] = item_s1.write_data;
					// Derived state follows only the exact page addresses
					case (item_s1.address)
						ADDR_WRAM0, ADDR_WRAM1: begin
							wram_d[0] = wram_select(rf_d[0]);
							wram_d[1] = wram_select(rf_d[1]);
						end
						ADDR_PRG0, ADDR_PRG1, ADDR_PRG2: begin
							prg_d[0] = prg_select(rf_d[2]);
							prg_d[1] = prg_select(rf_d[3]);
							prg_d[2] = prg_select(rf_d[4]);
						end
						ADDR_CHR: begin
							chr_d = rf_d[5][0];
						end
						ADDR_IRQ_LO: begin
							reload_d[7:0] = item_s1.write_data;
						end
						ADDR_IRQ_HI: begin
							reload_d[15:8] = item_s1.write_data;
						end
						ADDR_IRQ_ACK: begin
							irq_en_d   = irq_rep_q;
							irq_pend_d = 1'b0;
						end
						ADDR_IRQ_CTL: begin
							irq_rep_d  = item_s1.write_data[0];
							irq_en_d   = item_s1.write_data[1];
							irq_pend_d = 1'b0;
							if (item_s1.write_data[1]) begin
								cnt_d = {1'b0, reload_q};
							end
						end
						ADDR_MIRROR: begin
							mirror_d = ~rf_d[REG_MIRROR][1];
							nt_d     = rf_d[REG_MIRROR][1:0];
						end
						default: ;
					endcase
				end
			end
			OP_READ: begin
				rd_d = glyph_data;
			end
			OP_TICK: begin
				// Counter runs only while enabled; bit 16 fires the IRQ and reloads
				if (irq_en_q) begin
					if (cnt_sum[16]) begin
						irq_pend_d = 1'b1;
						cnt_d      = {1'b0, reload_q};
					end else begin
						cnt_d = cnt_sum;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				rf_q[i] <= '0;
			end
			prg_q      <= '{default: '0};
			wram_q     <= '{default: '0};
			chr_q      <= 1'b0;
			mirror_q   <= 1'b1;
			nt_q       <= '0;
			reload_q   <= '0;
			cnt_q      <= '0;
			irq_en_q   <= 1'b0;
			irq_rep_q  <= 1'b0;
			irq_pend_q <= 1'b0;
		end else if (adv_s1) begin
			rf_q       <= rf_d;
			prg_q      <= prg_d;
			wram_q     <= wram_d;
			chr_q      <= chr_d;
			mirror_q   <= mirror_d;
			nt_q       <= nt_d;
			reload_q   <= reload_d;
			cnt_q      <= cnt_d;
			irq_en_q   <= irq_en_d;
			irq_rep_q  <= irq_rep_d;
			irq_pend_q <= irq_pend_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= '{
				pad:               2'b00,
				irq_line:          irq_pend_d,
				nametable_control: nt_d,
				mirroring:         mirror_d,
				chr_bank_low:      chr_d,
				wram_bank_7000:    wram_d[1],
				wram_bank_6000:    wram_d[0],
				prg_bank_c000:     prg_d[2],
				prg_bank_a000:     prg_d[1],
				prg_bank_8000:     prg_d[0],
				read_data:         rd_d
			};
		end
	end

endmodule

FILE: hdl/cbkm_glyph.sv
// Glyph tile and bank byte lookup from the row and column registers.
module cbkm_glyph (
	input  cbkm_pkg::glyph_req_t req,
	output logic [7:0]           data
);
	import cbkm_pkg::*;

	logic [7:0]  row;
	logic [7:0]  col;
	logic        in_range;
	logic [13:0] code;
	logic [5:0]  page;
	logic [13:0] tile;

	assign row = req.row - GLYPH_BASE;
	assign col = req.col - GLYPH_BASE;
	assign in_range = (row < GLYPH_SPAN) && (col < GLYPH_SPAN);

	// code = col%32 + (row%16)*32 + (col/32)*512 + (row/16)*1536
	assign code = {9'd0, col[4:0]} + {5'd0, row[3:0], 5'd0} + {2'd0, col[7:5], 9'd0}
	            + {row[7:4], 10'd0} + {1'b0, row[7:4], 9'd0};
	assign page = code[13:8];
	// tile index times four
	assign tile = {glyph_page(page), code[7:0], 2'b00};

	always_comb begin
		data = '0;
		if (in_range && page < GLYPH_PAGES) begin
			if (req.address == ADDR_GLYPH_T) begin
				data = {tile[7:2], req.cfg[1:0]};
			end else if (req.address == ADDR_GLYPH_B) begin
				data = {req.cfg[2], 1'b1, tile[13:8]};
			end
		end
	end

endmodule

FILE: hdl/cbkm_checker.sv
// Port-level checks for the mapper core and the bind that attaches them.
module cbkm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// Input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled while result side empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:38] == 2'b00)
		else $error("result padding not zero");

	// Bank selects top out at 0x4F
	a_prg_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[14:8] < 7'd80) && (m_tdata[21:15] < 7'd80)
		&& (m_tdata[28:22] < 7'd80))
		else $error("program bank out of range");

endmodule

bind cartridge_bank_irq_kanji_mapper_core cbkm_checker u_cbkm_checker (.*);

FILE: dv/cbkm_mapper_checker.sv
// Checker for the bank mapper: predicts each result word and compares it with the DUT output.
`timescale 1ns / 1ps

module cbkm_mapper_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	output int          mismatches,
	output int          outstanding,
	output int          checked,
	output int          irq_raises
);
	import cbkm_pkg::*;

	// Glyph page remap, entry 0 in the low nibble
	localparam logic [143:0] KANJI_PAGE_MAP =
		144'hDD_FEDCBA9876543210_FEDCBA987654_1122_00;

	reg_byte_t   regs [16];
	logic [6:0]  prg_bank [3];
	logic [1:0]  wram_bank [2];
	logic        chr_bank;
	logic        mirror_sel;
	logic [1:0]  nt_ctl;
	logic [15:0] irq_latch;
	logic [16:0] irq_count;
	logic        irq_on;
	logic        irq_rearm;
	logic        irq_flag;

	out_item_t   status_q [$];
	out_item_t   due;
	out_item_t   seen;

	function automatic logic [6:0] prg_decode(input reg_byte_t r);
		if (r[6]) begin
			return 7'(8'h10 + r[5:0]);
		end
		return {3'd0, r[3:0]};
	endfunction

	function automatic logic [1:0] wram_decode(input reg_byte_t r);
		return {r[3], r[0]};
	endfunction

	function automatic reg_byte_t kanji_byte(input logic [15:0] addr);
		reg_byte_t   row;
		reg_byte_t   col;
		int          code;
		logic [15:0] tile;
		row = regs[REG_GLYPH_ROW] - GLYPH_BASE;
		col = regs[REG_GLYPH_COL] - GLYPH_BASE;
		if (addr != ADDR_GLYPH_T && addr != ADDR_GLYPH_B) begin
			return 8'h00;
		end
		if (row >= GLYPH_SPAN || col >= GLYPH_SPAN) begin
			return 8'h00;
		end
		code = (col % 32) + (row % 16) * 32 + (col / 32) * 512 + (row / 16) * 1536;
		if ((code >> 8) >= GLYPH_PAGES) begin
			return 8'h00;
		end
		tile = {2'b00, KANJI_PAGE_MAP[(code >> 8) * 4 +: 4], code[7:0], 2'b00};
		if (addr == ADDR_GLYPH_T) begin
			return tile[7:0] | {6'd0, regs[REG_GLYPH_CFG][1:0]};
		end
		return 8'h40 | {regs[REG_GLYPH_CFG][2], 7'd0} | tile[15:8];
	endfunction

	// Apply one input word to the predicted state, return the result word
	function automatic out_item_t mapper_step(input in_item_t w);
		out_item_t r;
		reg_byte_t rd;
		rd = 8'h00;
		case (w.opcode)
			OP_WRITE: begin
				if (w.address[15:12] == REG_PAGE) begin
					regs[w.address[11:8]] = w.write_data;
					case (w.address)
						ADDR_WRAM0, ADDR_WRAM1: begin
							wram_bank[0] = wram_decode(regs[ADDR_WRAM0[11:8]]);
							wram_bank[1] = wram_decode(regs[ADDR_WRAM1[11:8]]);
						end
						ADDR_PRG0, ADDR_PRG1, ADDR_PRG2: begin
							prg_bank[0] = prg_decode(regs[ADDR_PRG0[11:8]]);
							prg_bank[1] = prg_decode(regs[ADDR_PRG1[11:8]]);
							prg_bank[2] = prg_decode(regs[ADDR_PRG2[11:8]]);
						end
						ADDR_CHR: chr_bank = regs[ADDR_CHR[11:8]][0];
						ADDR_IRQ_LO: irq_latch[7:0] = w.write_data;
						ADDR_IRQ_HI: irq_latch[15:8] = w.write_data;
						ADDR_IRQ_ACK: begin
							irq_on   = irq_rearm;
							irq_flag = 1'b0;
						end
						ADDR_IRQ_CTL: begin
							irq_rearm = w.write_data[0];
							irq_on    = w.write_data[1];
							if (irq_on) begin
								irq_count = {1'b0, irq_latch};
							end
							irq_flag = 1'b0;
						end
						ADDR_MIRROR: begin
							mirror_sel = ~regs[REG_MIRROR][1];
							nt_ctl     = regs[REG_MIRROR][1:0];
						end
						default: ;
					endcase
				end
			end
			OP_READ: rd = kanji_byte(w.address);
			OP_TICK: begin
				// counter only runs while enabled; bit 16 fires and reloads
				if (irq_on) begin
					irq_count = irq_count + 17'(w.cycle_count);
					if (irq_count[16]) begin
						if (!irq_flag) begin
							irq_raises++;
						end
						irq_flag  = 1'b1;
						irq_count = {1'b0, irq_latch};
					end
				end
			end
			default: ;
		endcase
		r                   = '0;
		r.read_data         = rd;
		r.prg_bank_8000     = prg_bank[0];
		r.prg_bank_a000     = prg_bank[1];
		r.prg_bank_c000     = prg_bank[2];
		r.wram_bank_6000    = wram_bank[0];
		r.wram_bank_7000    = wram_bank[1];
		r.chr_bank_low      = chr_bank;
		r.mirroring         = mirror_sel;
		r.nametable_control = nt_ctl;
		r.irq_line          = irq_flag;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				regs[i] = 8'h00;
			end
			for (int i = 0; i < 3; i++) begin
				prg_bank[i] = 7'd0;
			end
			wram_bank[0] = 2'd0;
			wram_bank[1] = 2'd0;
			chr_bank     = 1'b0;
			mirror_sel   = 1'b1;
			nt_ctl       = 2'd0;
			irq_latch    = 16'd0;
			irq_count    = 17'd0;
			irq_on       = 1'b0;
			irq_rearm    = 1'b0;
			irq_flag     = 1'b0;
			status_q.delete();
			outstanding <= 0;
		end else begin
			// retire first: a word accepted now cannot show up at this edge
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					$error("result word %h with nothing predicted", m_tdata);
					mismatches++;
				end else begin
					due  = status_q.pop_front();
					seen = out_item_t'(m_tdata);
					check_field("read_data", due.read_data, seen.read_data);
					check_field("prg_bank_8000", due.prg_bank_8000, seen.prg_bank_8000);
					check_field("prg_bank_a000", due.prg_bank_a000, seen.prg_bank_a000);
					check_field("prg_bank_c000", due.prg_bank_c000, seen.prg_bank_c000);
					check_field("wram_bank_6000", due.wram_bank_6000, seen.wram_bank_6000);
					check_field("wram_bank_7000", due.wram_bank_7000, seen.wram_bank_7000);
					check_field("chr_bank_low", due.chr_bank_low, seen.chr_bank_low);
					check_field("mirroring", due.mirroring, seen.mirroring);
					check_field("nametable_control", due.nametable_control,
						seen.nametable_control);
					check_field("irq_line", due.irq_line, seen.irq_line);
					checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				status_q.push_back(mapper_step(in_item_t'({s_tuser, s_tdata})));
			end
			outstanding <= status_q.size();
		end
	end

endmodule

FILE: dv/cartridge_bank_irq_kanji_mapper_core_tb.sv
// Testbench top for the bank mapper: clock, reset, stimulus, ready pattern and verdict.
`timescale 1ns / 1ps

module cartridge_bank_irq_kanji_mapper_core_tb;
	import cbkm_pkg::*;

	// Opcode 3 is accepted and does nothing
	localparam logic [1:0] OP_IDLE = 2'd3;
	localparam int RANDOM_WORDS    = 870;
	localparam int QUIET_TAIL      = 120;  // last stretch runs with no idling

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // address[15:0], write_data[23:16], cycle_count[31:24]
	logic [1:0]  s_tuser;   // opcode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;   // read_data, prg x3, wram x2, chr, mirroring, nametable, irq

	int mismatches;
	int outstanding;
	int checked;
	int irq_raises;

	// Word counters for the run length and the summary
	int sent_words;
	int op_hits [4];

	// Idling switches, flipped by the stimulus
	bit sender_gaps   = 1'b1;
	bit receiver_gaps = 1'b1;
	int ready_hold    = 0;

	always #5 clk = ~clk;

	cartridge_bank_irq_kanji_mapper_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	cbkm_mapper_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.checked     (checked),
		.irq_raises  (irq_raises)
	);

	// Result side: m_tready drops in bursts of random length while receiver_gaps is set
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready   <= 1'b0;
		end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
			ready_hold <= $urandom_range(0, 13);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Base address of a register page, D000 + idx * 0x100
	function automatic logic [15:0] reg_page(input int idx);
		return {REG_PAGE, 4'(idx), 8'h00};
	endfunction

	// Called at a falling edge; returns at the falling edge after the handshake
	task automatic send_word(input logic [1:0] op, input logic [15:0] addr,
		input logic [7:0] wdata, input logic [7:0] cycles);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {cycles, wdata, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		op_hits[op]++;
		sent_words++;
	endtask

	// Hold the sender until every predicted word has come back
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Latch, enable, a run of ticks, sometimes an ack; the latch high byte leans high so it fires
	task automatic irq_burst;
		logic [7:0] ctl;
		send_word(OP_WRITE, ADDR_IRQ_LO, 8'($urandom), 8'($urandom));
		send_word(OP_WRITE, ADDR_IRQ_HI,
			($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'hF0, 8'hFF)) : 8'($urandom),
			8'($urandom));
		ctl    = 8'($urandom);
		ctl[1] = ($urandom_range(0, 4) != 0);
		send_word(OP_WRITE, ADDR_IRQ_CTL, ctl, 8'($urandom));
		repeat ($urandom_range(3, 12)) begin
			send_word(OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
		end
		if ($urandom_range(0, 1) == 0) begin
			send_word(OP_WRITE, ADDR_IRQ_ACK, 8'($urandom), 8'($urandom));
		end
	endtask

	// Row/column/config setup followed by glyph reads; coordinates mostly in range
	task automatic glyph_burst;
		send_word(OP_WRITE, reg_page(REG_GLYPH_COL),
			($urandom_range(0, 4) != 0) ? 8'($urandom_range(8'h20, 8'h7F)) : 8'($urandom),
			8'($urandom));
		send_word(OP_WRITE, reg_page(REG_GLYPH_ROW),
			($urandom_range(0, 4) != 0) ? 8'($urandom_range(8'h20, 8'h7F)) : 8'($urandom),
			8'($urandom));
		send_word(OP_WRITE, reg_page(REG_GLYPH_CFG), 8'($urandom), 8'($urandom));
		repeat ($urandom_range(2, 4)) begin
			send_word(OP_READ, ($urandom_range(0, 1) != 0) ? ADDR_GLYPH_T : ADDR_GLYPH_B,
				8'($urandom), 8'($urandom));
		end
	endtask

	task automatic single_word;
		int pick;
		logic [15:0] addr;
		pick = $urandom_range(0, 99);
		addr = 16'($urandom);
		if (pick < 25) begin
			send_word(OP_WRITE, reg_page($urandom_range(0, 15)), 8'($urandom), 8'($urandom));
		end else if (pick < 45) begin
			send_word(OP_TICK, addr, 8'($urandom), 8'($urandom));
		end else if (pick < 60) begin
			send_word(OP_READ, ($urandom_range(0, 1) != 0) ? ADDR_GLYPH_T : ADDR_GLYPH_B,
				8'($urandom), 8'($urandom));
		end else if (pick < 70) begin
			send_word(OP_READ, addr, 8'($urandom), 8'($urandom));
		end else if (pick < 80) begin
			// inside the window, mostly off the page boundary
			send_word(OP_WRITE, {REG_PAGE, addr[11:0]}, 8'($urandom), 8'($urandom));
		end else if (pick < 92) begin
			send_word(OP_WRITE, addr, 8'($urandom), 8'($urandom));
		end else begin
			send_word(OP_IDLE, addr, 8'($urandom), 8'($urandom));
		end
	endtask

	// Watchdog, well above the slowest legal run
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int goal;
		int kind;
		bit pressed;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = OP_WRITE;
		s_tdata  = '0;
		pressed  = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset state, bank extremes, irq fire/ack, glyph corners, noise
		send_word(OP_READ, ADDR_GLYPH_T, 8'hFF, 8'hFF);      // row/col regs zero: out of range
		send_word(OP_TICK, 16'hFFFF, 8'hFF, 8'hFF);          // disabled tick
		send_word(OP_WRITE, ADDR_WRAM0, 8'hFF, 8'h00);
		send_word(OP_WRITE, ADDR_WRAM1, 8'h09, 8'h00);
		send_word(OP_WRITE, ADDR_PRG0, 8'h7F, 8'h00);        // largest bank, 79
		send_word(OP_WRITE, ADDR_PRG1, 8'h0F, 8'h00);
		send_word(OP_WRITE, ADDR_PRG2, 8'hBF, 8'h00);        // bit 6 clear: low nibble only
		send_word(OP_WRITE, ADDR_CHR, 8'hFF, 8'h00);
		send_word(OP_WRITE, ADDR_MIRROR, 8'hFF, 8'h00);
		send_word(OP_WRITE, ADDR_IRQ_LO, 8'hF0, 8'h00);
		send_word(OP_WRITE, ADDR_IRQ_HI, 8'hFF, 8'h00);
		send_word(OP_WRITE, ADDR_IRQ_CTL, 8'h03, 8'h00);     // enable with rearm
		send_word(OP_TICK, 16'h0000, 8'h00, 8'hFF);          // crosses bit 16
		send_word(OP_WRITE, ADDR_IRQ_ACK, 8'h00, 8'h00);
		send_word(OP_TICK, 16'h0000, 8'h00, 8'h00);          // cycle_count of zero
		send_word(OP_TICK, 16'h0000, 8'h00, 8'h10);          // exactly reaches bit 16
		send_word(OP_WRITE, ADDR_IRQ_CTL, 8'h00, 8'h00);
		send_word(OP_WRITE, reg_page(REG_GLYPH_COL), 8'h7F, 8'h00);
		send_word(OP_WRITE, reg_page(REG_GLYPH_ROW), 8'h7F, 8'h00);
		send_word(OP_WRITE, reg_page(REG_GLYPH_CFG), 8'h07, 8'h00);
		send_word(OP_READ, ADDR_GLYPH_T, 8'h00, 8'h00);      // last glyph, tile byte
		send_word(OP_READ, ADDR_GLYPH_B, 8'h00, 8'h00);      // last glyph, bank byte
		send_word(OP_WRITE, reg_page(REG_GLYPH_COL), 8'h1F, 8'h00);  // wraps out of range
		send_word(OP_READ, ADDR_GLYPH_T, 8'h00, 8'h00);
		send_word(OP_WRITE, 16'hD0FF, 8'hFF, 8'hFF);         // in window, not a page
		send_word(OP_WRITE, 16'h0000, 8'hFF, 8'hFF);         // outside the window
		send_word(OP_READ, 16'hFFFF, 8'hFF, 8'hFF);
		send_word(OP_IDLE, 16'hFFFF, 8'hFF, 8'hFF);

		// Random: mostly well-formed bursts, the rest single words and noise
		goal = sent_words + RANDOM_WORDS;
		while (sent_words < goal) begin
			if (sent_words >= goal - QUIET_TAIL) begin
				sender_gaps   = 1'b0;
				receiver_gaps = 1'b0;
			end else if ($urandom_range(0, 59) == 0) begin
				sender_gaps   = ($urandom_range(0, 3) != 0);
				receiver_gaps = ($urandom_range(0, 3) != 0);
			end
			if (!pressed && sent_words >= goal - RANDOM_WORDS / 2) begin
				pressed = 1'b1;
				drain();
			end
			kind = $urandom_range(0, 99);
			if (kind < 12) begin
				irq_burst();
			end else if (kind < 24) begin
				glyph_burst();
			end else begin
				single_word();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("run: %0d writes, %0d reads, %0d ticks, %0d no-ops sent; %0d results checked",
			op_hits[OP_WRITE], op_hits[OP_READ], op_hits[OP_TICK], op_hits[OP_IDLE], checked);
		$display("run: %0d IRQ assertions predicted, %0d mismatches", irq_raises, mismatches);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/cbkm_pkg.sv
hdl/cbkm_glyph.sv
hdl/cartridge_bank_irq_kanji_mapper_core.sv
hdl/cbkm_checker.sv
dv/cbkm_mapper_checker.sv
dv/cartridge_bank_irq_kanji_mapper_core_tb.sv
